// File: rtl/flcl_pkg.sv
// ----------------------------------------------------------------------------
// flcl_pkg: shared types and constants of the indexed list unit
// Record, transfer and command types, operation and status codes.
// ----------------------------------------------------------------------------
package flcl_pkg;

  localparam int Depth   = 64;
  localparam int IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW    = $clog2(Depth + 1);
  localparam int GrpSize = 8;
  localparam int NumGrp  = (Depth + GrpSize - 1) / GrpSize;
  localparam logic [6:0] CapRst = 7'd64;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_READ   = 3'd3,
    FN_WRITE  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } rec_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  index;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [15:0] in_year;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
    logic [6:0]  list_length;
  } out_item_t;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic            wr;
    logic            rd;
    logic [IdxW-1:0] k;
    rec_t            rec;
  } cmd_t;

endpackage

// File: rtl/flcl_cell.sv
// ----------------------------------------------------------------------------
// flcl_cell: one list position
// Holds one record and takes it from a neighbor, the command or itself.
// ----------------------------------------------------------------------------
module flcl_cell (
  input  logic                    clk_i,
  input  logic [flcl_pkg::IdxW-1:0] idx_i,
  input  flcl_pkg::cmd_t          cmd_i,
  input  flcl_pkg::rec_t          left_i,
  input  flcl_pkg::rec_t          right_i,
  output flcl_pkg::rec_t          rec_o,
  output flcl_pkg::rec_t          rd_o
);
  import flcl_pkg::*;

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (cmd_i.ins && (idx_i > cmd_i.k)) begin
      rec_d = left_i;
    end else if (cmd_i.ins && (idx_i == cmd_i.k)) begin
      rec_d = cmd_i.rec;
    end else if (cmd_i.rem && (idx_i >= cmd_i.k)) begin
      rec_d = right_i;
    end else if (cmd_i.wr && (idx_i == cmd_i.k)) begin
      rec_d = cmd_i.rec;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;
  assign rd_o  = (cmd_i.rd && (idx_i == cmd_i.k)) ? rec_q : '0;

endmodule

// File: rtl/flcl_rdsel.sv
// ----------------------------------------------------------------------------
// flcl_rdsel: read return tree
// Combines the cell read outputs through a registered group stage.
// ----------------------------------------------------------------------------
module flcl_rdsel (
  input  logic                         clk_i,
  input  flcl_pkg::rec_t [flcl_pkg::Depth-1:0] rd_i,
  output flcl_pkg::rec_t               rec_o
);
  import flcl_pkg::*;

  rec_t [NumGrp-1:0] grp_q, grp_d;

  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NumGrp; g++) begin
      for (int j = 0; j < GrpSize; j++) begin
        if (g * GrpSize + j < Depth) begin
          grp_d[g] = grp_d[g] | rd_i[g * GrpSize + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    rec_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rec_o = rec_o | grp_q[g];
    end
  end

endmodule

// File: rtl/fixed_capacity_indexed_list_unit.sv
// ----------------------------------------------------------------------------
// fixed_capacity_indexed_list_unit: ordered list of date records
// Append, insert, remove, read and write on a list held in a row of cells.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one operation (func, index and a
// record). Each operation gives exactly one output transfer with a status,
// the record read (zero unless a read succeeds) and the list length after
// the operation. The capacity register is written through cfg_we_i and
// cfg_wdata_i; write it only while the unit is idle, as the unit itself
// does not enforce this. Values above the store depth act as the depth.
// Every entry sits in its own cell, so an insert or remove shifts every
// entry from the given index on in the cycle of the input transfer. A read
// result is captured by the group stage of the read tree at the input
// transfer and then by the output register, which offers it. One
// operation is in flight at a time, and the next input transfer is taken
// only after the result transfer has cleared the output register.
// Reset empties the list and sets the capacity to 64. While the receiver
// stalls, the result holds and no further input transfer is taken.
// ----------------------------------------------------------------------------
module fixed_capacity_indexed_list_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  flcl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output flcl_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);
  import flcl_pkg::*;

  logic [6:0]      cap_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q;
  logic            out_valid_q;
  out_item_t       out_q;
  logic [1:0]      status_q, status_d;
  logic            in_fire;
  logic [CntW-1:0] limit;
  cmd_t            cmd, cmd_gated;
  rec_t            rd_rec;
  rec_t [Depth-1:0] cell_rec;
  rec_t [Depth-1:0] cell_rd;

  assign in_ready_o = !busy_q && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (32'(cap_q) > Depth) begin
      limit = CntW'(Depth);
    end else begin
      limit = CntW'(cap_q);
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.rec  = '{year: in_item_i.in_year, month: in_item_i.in_month,
                 day: in_item_i.in_day};
    cmd.k    = IdxW'(in_item_i.index);
    cnt_d    = cnt_q;
    status_d = ST_OK;
    case (in_item_i.func)
      FN_APPEND: begin
        if (cnt_q < limit) begin
          cmd.wr = 1'b1;
          cmd.k  = IdxW'(cnt_q);
          cnt_d  = cnt_q + 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      FN_INSERT: begin
        if (cnt_q >= limit) begin
          status_d = ST_FULL;
        end else if (32'(in_item_i.index) > 32'(cnt_q)) begin
          status_d = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (32'(in_item_i.index) < 32'(cnt_q)) begin
          cmd.rem = 1'b1;
          cnt_d   = cnt_q - 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      FN_READ: begin
        if (32'(in_item_i.index) < 32'(cnt_q)) begin
          cmd.rd = 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      FN_WRITE: begin
        if (32'(in_item_i.index) < 32'(cnt_q)) begin
          cmd.wr = 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd_gated     = cmd;
    cmd_gated.ins = cmd.ins && in_fire;
    cmd_gated.rem = cmd.rem && in_fire;
    cmd_gated.wr  = cmd.wr && in_fire;
    cmd_gated.rd  = cmd.rd && in_fire;
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    rec_t left_rec, right_rec;
    if (g == 0) begin : g_first
      assign left_rec = '0;
    end else begin : g_mid_l
      assign left_rec = cell_rec[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_rec = '0;
    end else begin : g_mid_r
      assign right_rec = cell_rec[g+1];
    end
    flcl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(g)),
      .cmd_i   (cmd_gated),
      .left_i  (left_rec),
      .right_i (right_rec),
      .rec_o   (cell_rec[g]),
      .rd_o    (cell_rd[g])
    );
  end

  flcl_rdsel u_rdsel (
    .clk_i (clk_i),
    .rd_i  (cell_rd),
    .rec_o (rd_rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapRst;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        cnt_q <= cnt_d;
      end
      busy_q <= in_fire;
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
    end
    if (busy_q) begin
      out_q.status      <= status_q;
      out_q.out_day     <= rd_rec.day;
      out_q.out_month   <= rd_rec.month;
      out_q.out_year    <= rd_rec.year;
      out_q.list_length <= 7'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
